/* rtl/msq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum move sequencer package
// Shared codes, widths and the wheel target arithmetic for the sequencer core.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int SPEED_W = 16;
  localparam int MIX_W   = SPEED_W + 2;
  localparam int TPM_W   = 16;
  localparam int WHEEL_W = 24;
  localparam int PROD_W  = MIX_W + TPM_W + 1;
  localparam int FRAC_W  = 10;

  localparam logic [TPM_W-1:0] TPM_RESET = 16'd1000;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_DRIVE = 2'd2;

  localparam logic [1:0] CMD_STOP  = 2'd0;
  localparam logic [1:0] CMD_TIMED = 2'd1;
  localparam logic [1:0] CMD_DIST  = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_TIMED = 2'd1,
    MODE_DIST  = 2'd2
  } mode_t;

  // Wheel target in ticks per second, rounded toward minus infinity.
  function automatic logic signed [WHEEL_W-1:0] wheel_target(
    input logic signed [MIX_W-1:0] mix,
    input logic [TPM_W-1:0] tpm
  );
    logic signed [PROD_W-1:0] prod;
    prod = PROD_W'(mix) * $signed({{(PROD_W-TPM_W){1'b0}}, tpm});
    return prod[FRAC_W+WHEEL_W-1:FRAC_W];
  endfunction

endpackage
`default_nettype wire

/* rtl/mecanum_move_sequencer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum move sequencer core
// Runs timed and distance moves and mixes drive speeds into four wheel targets.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_valid/in_ready channel. Each item is a tick, a
// motion command or a direct drive request, selected by op. Every accepted
// transaction yields exactly one result transaction on out_valid/out_ready,
// in order. An item sits in the input register, where the move state is
// updated and the four wheel multiplies are done, and the result is
// registered at the output once the output register is free. One item is
// accepted per cycle while the output is taken; the rate is set by the single
// state update pass between the two registers. When the receiver stalls, the
// result holds in the output register and the input register fills; in_ready
// drops only when both are occupied. ticks_per_meter is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, which the
// block does not enforce. Reset clears the move state, the drive speeds and
// both pipeline registers and sets ticks_per_meter to 1000.
// ----------------------------------------------------------------------------
module mecanum_move_sequencer_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [15:0]         cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          op,
  input  wire logic [1:0]          cmd_type,
  input  wire logic signed [15:0]  fwd_speed,
  input  wire logic signed [15:0]  strafe_speed,
  input  wire logic signed [15:0]  rotate_speed,
  input  wire logic [31:0]         duration_ms,
  input  wire logic [22:0]         target_distance,
  input  wire logic [31:0]         now_ms,
  input  wire logic signed [23:0]  travelled_distance,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [23:0]       wheel_front_left,
  output logic signed [23:0]       wheel_front_right,
  output logic signed [23:0]       wheel_back_right,
  output logic signed [23:0]       wheel_back_left,
  output logic                     targets_valid,
  output logic                     reset_distance,
  output logic [1:0]               motion_mode
);

  logic [msq_pkg::TPM_W-1:0] ticks_per_meter;

  logic                s1_valid;
  logic [1:0]          s1_op;
  logic [1:0]          s1_cmd_type;
  logic signed [15:0]  s1_fwd;
  logic signed [15:0]  s1_strafe;
  logic signed [15:0]  s1_rotate;
  logic [31:0]         s1_duration;
  logic [22:0]         s1_target;
  logic [31:0]         s1_now;
  logic signed [23:0]  s1_travelled;

  msq_pkg::mode_t      mode, mode_next;
  logic signed [15:0]  cmd_fwd, cmd_fwd_next;
  logic signed [15:0]  cmd_strafe, cmd_strafe_next;
  logic signed [15:0]  cmd_rotate, cmd_rotate_next;
  logic signed [15:0]  drive_fwd, drive_fwd_next;
  logic signed [15:0]  drive_strafe, drive_strafe_next;
  logic signed [15:0]  drive_rotate, drive_rotate_next;
  logic [31:0]         limit_duration, limit_duration_next;
  logic [22:0]         limit_distance, limit_distance_next;
  logic [31:0]         start_time, start_time_next;

  logic                out_free;
  logic                advance;
  logic                move_ended;
  logic [31:0]         elapsed;
  logic                res_tick;
  logic                res_reset_distance;
  logic signed [msq_pkg::MIX_W-1:0] f_x, s_x, r_x;
  logic signed [msq_pkg::MIX_W-1:0] mix_fl, mix_fr, mix_br, mix_bl;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  assign elapsed = s1_now - start_time;

  always_comb begin
    move_ended          = 1'b0;
    mode_next           = mode;
    cmd_fwd_next        = cmd_fwd;
    cmd_strafe_next     = cmd_strafe;
    cmd_rotate_next     = cmd_rotate;
    drive_fwd_next      = drive_fwd;
    drive_strafe_next   = drive_strafe;
    drive_rotate_next   = drive_rotate;
    limit_duration_next = limit_duration;
    limit_distance_next = limit_distance;
    start_time_next     = start_time;
    res_tick            = 1'b0;
    res_reset_distance  = 1'b0;
    case (s1_op)
      msq_pkg::OP_TICK: begin
        res_tick = 1'b1;
        if (mode == msq_pkg::MODE_TIMED) begin
          move_ended = elapsed >= limit_duration;
        end else if (mode == msq_pkg::MODE_DIST) begin
          move_ended = s1_travelled >= $signed({1'b0, limit_distance});
        end
        if (mode == msq_pkg::MODE_TIMED || mode == msq_pkg::MODE_DIST) begin
          if (move_ended) begin
            mode_next         = msq_pkg::MODE_NONE;
            drive_fwd_next    = '0;
            drive_strafe_next = '0;
            drive_rotate_next = '0;
          end else begin
            drive_fwd_next    = cmd_fwd;
            drive_strafe_next = cmd_strafe;
            drive_rotate_next = cmd_rotate;
          end
        end
      end
      msq_pkg::OP_CMD: begin
        case (s1_cmd_type)
          msq_pkg::CMD_TIMED: begin
            mode_next           = msq_pkg::MODE_TIMED;
            cmd_fwd_next        = s1_fwd;
            cmd_strafe_next     = s1_strafe;
            cmd_rotate_next     = s1_rotate;
            limit_duration_next = s1_duration;
            start_time_next     = s1_now;
          end
          msq_pkg::CMD_DIST: begin
            mode_next           = msq_pkg::MODE_DIST;
            cmd_fwd_next        = s1_fwd;
            cmd_strafe_next     = s1_strafe;
            cmd_rotate_next     = s1_rotate;
            limit_distance_next = s1_target;
            start_time_next     = s1_now;
            drive_fwd_next      = s1_fwd;
            drive_strafe_next   = s1_strafe;
            drive_rotate_next   = s1_rotate;
            res_reset_distance  = 1'b1;
          end
          default: begin
            drive_fwd_next    = '0;
            drive_strafe_next = '0;
            drive_rotate_next = '0;
          end
        endcase
      end
      msq_pkg::OP_DRIVE: begin
        drive_fwd_next    = s1_fwd;
        drive_strafe_next = s1_strafe;
        drive_rotate_next = s1_rotate;
      end
      default: begin
      end
    endcase
  end

  assign f_x = msq_pkg::MIX_W'(drive_fwd_next);
  assign s_x = msq_pkg::MIX_W'(drive_strafe_next);
  assign r_x = msq_pkg::MIX_W'(drive_rotate_next);

  assign mix_fl = f_x - s_x - r_x;
  assign mix_fr = f_x + s_x + r_x;
  assign mix_br = f_x - s_x + r_x;
  assign mix_bl = f_x + s_x - r_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_meter <= msq_pkg::TPM_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_meter <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op        <= op;
      s1_cmd_type  <= cmd_type;
      s1_fwd       <= fwd_speed;
      s1_strafe    <= strafe_speed;
      s1_rotate    <= rotate_speed;
      s1_duration  <= duration_ms;
      s1_target    <= target_distance;
      s1_now       <= now_ms;
      s1_travelled <= travelled_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= msq_pkg::MODE_NONE;
      cmd_fwd        <= '0;
      cmd_strafe     <= '0;
      cmd_rotate     <= '0;
      drive_fwd      <= '0;
      drive_strafe   <= '0;
      drive_rotate   <= '0;
      limit_duration <= '0;
      limit_distance <= '0;
      start_time     <= '0;
    end else if (advance) begin
      mode           <= mode_next;
      cmd_fwd        <= cmd_fwd_next;
      cmd_strafe     <= cmd_strafe_next;
      cmd_rotate     <= cmd_rotate_next;
      drive_fwd      <= drive_fwd_next;
      drive_strafe   <= drive_strafe_next;
      drive_rotate   <= drive_rotate_next;
      limit_duration <= limit_duration_next;
      limit_distance <= limit_distance_next;
      start_time     <= start_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (res_tick) begin
        wheel_front_left  <= msq_pkg::wheel_target(mix_fl, ticks_per_meter);
        wheel_front_right <= msq_pkg::wheel_target(mix_fr, ticks_per_meter);
        wheel_back_right  <= msq_pkg::wheel_target(mix_br, ticks_per_meter);
        wheel_back_left   <= msq_pkg::wheel_target(mix_bl, ticks_per_meter);
      end else begin
        wheel_front_left  <= '0;
        wheel_front_right <= '0;
        wheel_back_right  <= '0;
        wheel_back_left   <= '0;
      end
      targets_valid  <= res_tick;
      reset_distance <= res_reset_distance;
      motion_mode    <= mode_next;
    end
  end

`ifndef ASSERT_OFF
  a_reset_distance_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_distance |-> motion_mode == msq_pkg::MODE_DIST)
    else $error("reset_distance raised outside a distance move");

  a_tick_or_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(targets_valid && reset_distance))
    else $error("tick result also flags a distance reset");

  a_idle_wheels_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !targets_valid |-> wheel_front_left == '0 && wheel_front_right == '0 &&
      wheel_back_right == '0 && wheel_back_left == '0)
    else $error("non-tick result carries wheel targets");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with a free pipeline slot");
`endif

endmodule
`default_nettype wire

/* tb/mecanum_move_sequencer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum move sequencer core testbench
// Drives ticks, motion commands and direct drive requests through the
// valid/ready input, predicts the move state and the four wheel targets for
// every accepted transaction, and compares each result transaction field by
// field. Directed cases cover field extremes, timer wrap and move endings.
// Random timed and distance move sequences follow under several
// ticks_per_meter settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module mecanum_move_sequencer_core_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  cmd;
    logic [15:0] fwd;
    logic [15:0] strafe;
    logic [15:0] rotate;
    logic [31:0] duration;
    logic [22:0] target;
    logic [31:0] now;
    logic [23:0] travelled;
  } move_item_t;

  typedef struct packed {
    logic signed [23:0] front_left;
    logic signed [23:0] front_right;
    logic signed [23:0] back_right;
    logic signed [23:0] back_left;
    logic               targets_ok;
    logic               clear_distance;
    msq_pkg::mode_t     mode;
  } wheel_set_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  move_item_t cur_item = '0;

  logic in_ready;
  logic out_valid;
  logic signed [23:0] wheel_front_left;
  logic signed [23:0] wheel_front_right;
  logic signed [23:0] wheel_back_right;
  logic signed [23:0] wheel_back_left;
  logic targets_valid;
  logic reset_distance;
  logic [1:0] motion_mode;

  move_item_t pending_moves[$];
  wheel_set_t expected_targets[$];
  wheel_set_t want_targets;

  // Predicted block state.
  logic [15:0] tpm_model = msq_pkg::TPM_RESET;
  msq_pkg::mode_t run_mode = msq_pkg::MODE_NONE;
  logic signed [15:0] cmd_fwd_m = '0, cmd_strafe_m = '0, cmd_rotate_m = '0;
  logic signed [15:0] drv_fwd = '0, drv_strafe = '0, drv_rotate = '0;
  logic [31:0] run_duration = '0;
  logic [22:0] run_target = '0;
  logic [31:0] run_start = '0;

  int mismatch_count = 0;
  int cycle_count = 0;
  int items_queued = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int gap_now;
  int stall_now;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  logic [31:0] ms_clock = '0;

  mecanum_move_sequencer_core dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .op                 (cur_item.op),
    .cmd_type           (cur_item.cmd),
    .fwd_speed          (cur_item.fwd),
    .strafe_speed       (cur_item.strafe),
    .rotate_speed       (cur_item.rotate),
    .duration_ms        (cur_item.duration),
    .target_distance    (cur_item.target),
    .now_ms             (cur_item.now),
    .travelled_distance (cur_item.travelled),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .wheel_front_left   (wheel_front_left),
    .wheel_front_right  (wheel_front_right),
    .wheel_back_right   (wheel_back_right),
    .wheel_back_left    (wheel_back_left),
    .targets_valid      (targets_valid),
    .reset_distance     (reset_distance),
    .motion_mode        (motion_mode)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The mixed speed scaled by ticks per metre, floored by the shift.
  function automatic logic signed [23:0] mix_to_wheel(input int mix);
    longint prod;
    prod = longint'(mix) * longint'(tpm_model);
    prod = prod >>> 10;
    return prod[23:0];
  endfunction

  function automatic wheel_set_t predict_wheel_targets(input move_item_t it);
    wheel_set_t res;
    logic expired;
    logic [31:0] elapsed;
    int f, s, r;
    res = '0;
    case (it.op)
      msq_pkg::OP_TICK: begin
        expired = 1'b0;
        elapsed = it.now - run_start;
        if (run_mode == msq_pkg::MODE_TIMED) begin
          expired = elapsed >= run_duration;
        end else if (run_mode == msq_pkg::MODE_DIST) begin
          expired = $signed(it.travelled) >= $signed({1'b0, run_target});
        end
        if (run_mode != msq_pkg::MODE_NONE) begin
          if (expired) begin
            drv_fwd = '0;
            drv_strafe = '0;
            drv_rotate = '0;
            run_mode = msq_pkg::MODE_NONE;
          end else begin
            drv_fwd = cmd_fwd_m;
            drv_strafe = cmd_strafe_m;
            drv_rotate = cmd_rotate_m;
          end
        end
        f = drv_fwd;
        s = drv_strafe;
        r = drv_rotate;
        res.front_left = mix_to_wheel(f - s - r);
        res.front_right = mix_to_wheel(f + s + r);
        res.back_right = mix_to_wheel(f - s + r);
        res.back_left = mix_to_wheel(f + s - r);
        res.targets_ok = 1'b1;
      end
      msq_pkg::OP_CMD: begin
        if (it.cmd == msq_pkg::CMD_TIMED) begin
          run_mode = msq_pkg::MODE_TIMED;
          cmd_fwd_m = it.fwd;
          cmd_strafe_m = it.strafe;
          cmd_rotate_m = it.rotate;
          run_duration = it.duration;
          run_start = it.now;
        end else if (it.cmd == msq_pkg::CMD_DIST) begin
          run_mode = msq_pkg::MODE_DIST;
          cmd_fwd_m = it.fwd;
          cmd_strafe_m = it.strafe;
          cmd_rotate_m = it.rotate;
          run_target = it.target;
          run_start = it.now;
          drv_fwd = it.fwd;
          drv_strafe = it.strafe;
          drv_rotate = it.rotate;
          res.clear_distance = 1'b1;
        end else begin
          drv_fwd = '0;
          drv_strafe = '0;
          drv_rotate = '0;
        end
      end
      msq_pkg::OP_DRIVE: begin
        drv_fwd = it.fwd;
        drv_strafe = it.strafe;
        drv_rotate = it.rotate;
      end
      default: begin
      end
    endcase
    res.mode = run_mode;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic signed [23:0] got,
                             input logic signed [23:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sender: one transaction at a time from the pending queue, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      gap_now = send_gap;
      if (in_valid) begin
        expected_targets.push_back(predict_wheel_targets(cur_item));
        if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
        gap_now = sender_calm ? 0 : $urandom_range(0, 15);
      end
      if (gap_now == 0 && pending_moves.size() != 0) begin
        cur_item <= pending_moves.pop_front();
        in_valid <= 1'b1;
        send_gap <= 0;
      end else begin
        in_valid <= 1'b0;
        send_gap <= (gap_now == 0) ? 0 : gap_now - 1;
      end
    end
  end

  // Receiver: checks every result transaction, then stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else if (!out_ready) begin
      if (recv_stall == 0) out_ready <= 1'b1;
      else recv_stall <= recv_stall - 1;
    end else if (out_valid) begin
      if (expected_targets.size() == 0) begin
        report_mismatch("result transaction with no item pending");
      end else begin
        want_targets = expected_targets.pop_front();
        check_field("wheel_front_left", wheel_front_left, want_targets.front_left);
        check_field("wheel_front_right", wheel_front_right, want_targets.front_right);
        check_field("wheel_back_right", wheel_back_right, want_targets.back_right);
        check_field("wheel_back_left", wheel_back_left, want_targets.back_left);
        check_field("targets_valid", {23'b0, targets_valid},
                    {23'b0, want_targets.targets_ok});
        check_field("reset_distance", {23'b0, reset_distance},
                    {23'b0, want_targets.clear_distance});
        check_field("motion_mode", {22'b0, motion_mode}, {22'b0, want_targets.mode});
      end
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      stall_now = receiver_calm ? 0 : $urandom_range(0, 15);
      if (stall_now != 0) begin
        out_ready <= 1'b0;
        recv_stall <= stall_now - 1;
      end
    end
  end

  function automatic move_item_t make_item(
    input logic [1:0] op, input logic [1:0] cmd,
    input logic [15:0] fwd, input logic [15:0] strafe, input logic [15:0] rotate,
    input logic [31:0] duration, input logic [22:0] target,
    input logic [31:0] now, input logic [23:0] travelled
  );
    move_item_t it;
    it.op = op;
    it.cmd = cmd;
    it.fwd = fwd;
    it.strafe = strafe;
    it.rotate = rotate;
    it.duration = duration;
    it.target = target;
    it.now = now;
    it.travelled = travelled;
    return it;
  endfunction

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_item(input move_item_t it);
    pending_moves.push_back(it);
    items_queued++;
  endtask

  task automatic queue_directed_items();
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_DRIVE, msq_pkg::CMD_DIST, 16'h7FFF, 16'h8000, 16'h8000,
                         32'hFFFF_FFFF, 23'h7F_FFFF, 32'h0, 24'h80_0000));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_TIMED, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'hFFFF_FFFF, 24'h7F_FFFF));
    queue_item(make_item(msq_pkg::OP_DRIVE, msq_pkg::CMD_STOP, 16'h8000, 16'h7FFF, 16'h7FFF,
                         32'h0, 23'h0, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'h0, 24'h0));
    // A distance move that a negative distance cannot end.
    queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_DIST, 16'd100, 16'hFFCE, 16'd25,
                         32'h0, 23'h7F_FFFF, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'h0, 24'h80_0000));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'h0, 24'h7F_FFFF));
    // A timed move across the wrap of the millisecond clock.
    queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_TIMED, 16'hFC18, 16'd300, 16'hFFF9,
                         32'd10, 23'h0, 32'hFFFF_FFFA, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'hFFFF_FFFE, 24'h0));
    queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_STOP, 16'h1111, 16'h2222, 16'h3333,
                         32'h0, 23'h0, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'd2, 24'h0));
    queue_item(make_item(msq_pkg::OP_DRIVE, msq_pkg::CMD_STOP, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         32'h0, 23'h0, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'd3, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'd4, 24'h0));
    // A zero duration ends at the first tick.
    queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_TIMED, 16'h7FFF, 16'h7FFF, 16'h8000,
                         32'h0, 23'h0, 32'd5, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'd5, 24'h0));
    queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_TIMED, 16'h8000, 16'h8000, 16'h8000,
                         32'hFFFF_FFFF, 23'h0, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'hFFFF_FFFE, 24'h0));
    // A zero target ends at the first tick with no distance travelled.
    queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_DIST, 16'd512, 16'd0, 16'hFE00,
                         32'h0, 23'h0, 32'd123, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'd124, 24'h0));
    queue_item(make_item(msq_pkg::OP_DRIVE, msq_pkg::CMD_STOP, 16'd1234, 16'hFB2E, 16'd77,
                         32'h0, 23'h0, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'h0, 24'h0));
    queue_item(make_item(msq_pkg::OP_TICK, msq_pkg::CMD_STOP, 16'h0, 16'h0, 16'h0,
                         32'h0, 23'h0, 32'h0, 24'h0));
  endtask

  // Mostly well-formed moves followed by ticks, with stops, direct drives
  // and fully random transactions mixed in.
  task automatic queue_random_items(input int count);
    int stop_at;
    int kind;
    logic [31:0] dur;
    logic [22:0] goal;
    logic [23:0] trav;
    stop_at = items_queued + count;
    while (items_queued < stop_at) begin
      kind = $urandom_range(0, 4);
      if (kind == 4) begin
        repeat ($urandom_range(1, 3)) begin
          queue_item(make_item(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
                               rand_speed(), rand_speed(), rand_speed(), $urandom,
                               23'($urandom), $urandom, 24'($urandom)));
        end
      end else begin
        if ($urandom_range(0, 7) == 0) ms_clock = $urandom;
        dur = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
        goal = ($urandom_range(0, 7) == 0) ? 23'($urandom) : 23'($urandom_range(0, 3000));
        trav = 24'(-$urandom_range(0, 200));
        queue_item(make_item(msq_pkg::OP_CMD,
                             (kind < 2) ? msq_pkg::CMD_TIMED : msq_pkg::CMD_DIST,
                             rand_speed(), rand_speed(), rand_speed(), dur, goal,
                             ms_clock, 24'($urandom)));
        repeat ($urandom_range(1, 12)) begin
          ms_clock += $urandom_range(0, 12);
          trav += 24'($urandom_range(0, 600));
          case ($urandom_range(0, 9))
            0: queue_item(make_item(msq_pkg::OP_CMD, msq_pkg::CMD_STOP, rand_speed(),
                                    rand_speed(), rand_speed(), $urandom, 23'($urandom),
                                    ms_clock, trav));
            1: queue_item(make_item(msq_pkg::OP_DRIVE, 2'($urandom_range(0, 2)),
                                    rand_speed(), rand_speed(), rand_speed(), $urandom,
                                    23'($urandom), ms_clock, trav));
            default: queue_item(make_item(msq_pkg::OP_TICK, 2'($urandom_range(0, 2)),
                                          rand_speed(), rand_speed(), rand_speed(),
                                          $urandom, 23'($urandom), ms_clock, trav));
          endcase
        end
      end
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_moves.size() != 0 || in_valid || expected_targets.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_ticks_per_meter(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tpm_model = value;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] tpm_plan[5];
    tpm_plan = '{16'd65535, 16'd1, 16'($urandom_range(2, 65534)), 16'd1000, 16'd65535};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    queue_directed_items();
    wait_for_drain();
    foreach (tpm_plan[i]) begin
      set_ticks_per_meter(tpm_plan[i]);
      queue_random_items(PHASE_ITEMS);
      wait_for_drain();
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
